// ----- hdl/signed_radix_digit_add_sub_top_defines.svh -----
`ifndef SIGNED_RADIX_DIGIT_ADD_SUB_TOP_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_ADD_SUB_TOP_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SRDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define SRDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/srda_pkg.sv -----
package srda_pkg;

  localparam int DigitW      = 6;
  localparam int MaxDigitsDef = 32;

  localparam logic [DigitW-1:0] RadixReset = 6'd19;
  localparam logic [DigitW-1:0] RadixMin   = 6'd2;
  localparam logic [DigitW-1:0] RadixMax   = 6'd36;

  typedef logic [DigitW-1:0] digit_t;

  // Control of the shared digit unit
  typedef struct packed {
    logic sub;  // 1: x - y - cin, 0: x + y + cin
    logic cin;  // incoming carry or borrow
  } unit_ctl_t;

endpackage

// ----- hdl/srda_digit_unit.sv -----
module srda_digit_unit (
  input  srda_pkg::digit_t    x_i,
  input  srda_pkg::digit_t    y_i,
  input  srda_pkg::digit_t    radix_i,
  input  srda_pkg::unit_ctl_t ctl_i,
  output srda_pkg::digit_t    d_o,
  output logic                co_o
);

  logic [srda_pkg::DigitW:0] sum;
  logic [srda_pkg::DigitW:0] sub_amt;
  logic [srda_pkg::DigitW:0] x_ext;
  logic [srda_pkg::DigitW:0] r_ext;
  logic [srda_pkg::DigitW:0] res;

  // One radix digit add or subtract with carry/borrow
  always_comb begin
    x_ext   = {1'b0, x_i};
    r_ext   = {1'b0, radix_i};
    sum     = x_ext + {1'b0, y_i} + {{srda_pkg::DigitW{1'b0}}, ctl_i.cin};
    sub_amt = {1'b0, y_i} + {{srda_pkg::DigitW{1'b0}}, ctl_i.cin};
    if (!ctl_i.sub) begin
      if (sum >= r_ext) begin
        res  = sum - r_ext;
        co_o = 1'b1;
      end else begin
        res  = sum;
        co_o = 1'b0;
      end
    end else begin
      if (x_ext >= sub_amt) begin
        res  = x_ext - sub_amt;
        co_o = 1'b0;
      end else begin
        res  = x_ext + r_ext - sub_amt;
        co_o = 1'b1;
      end
    end
    d_o = res[srda_pkg::DigitW-1:0];
  end

endmodule

// ----- hdl/signed_radix_digit_add_sub_top.sv -----
// Channel   Dir  tdata (low bit up)           tuser (low bit up)          tlast
// s_axis    in   digit_a[5:0] digit_b[11:6]   func[0] neg_a[1] neg_b[2]   last pair
// m_axis    out  digit[5:0]                   negative[0] bad_input[1]    last_res
// cfg       in   radix[5:0] on cfg_we_i
//
// Loading accepts one digit pair per cycle. After the last pair, the stored pairs
// pass through the shared digit unit for the magnitude compare (opposite effective
// signs only) and then for the add or subtract pass. Each result digit then goes
// through a result memory read state and an output state that holds through any
// stall on m_axis; an error result goes out the cycle after the last pair.
// s_axis_tready is high only while loading. Reset clears all control state; the
// digit memories need no clearing.
`include "signed_radix_digit_add_sub_top_defines.svh"

module signed_radix_digit_add_sub_top #(
  parameter int MAX_DIGITS = srda_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,    // radix
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // digit_a[5:0], digit_b[11:6], zero fill
  input  logic [2:0]  s_axis_tuser,   // func[0], neg_a[1], neg_b[2]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // digit[5:0], zero fill
  output logic [1:0]  m_axis_tuser,   // negative[0], bad_input[1]
  output logic        m_axis_tlast
);

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int AW = $clog2(MAX_DIGITS);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_DIGITS);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_ARITH = 3'd2;
  localparam logic [2:0] S_EMRD  = 3'd3;
  localparam logic [2:0] S_EMOUT = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          err_q, err_d;
  srda_pkg::digit_t max_q, max_d;
  srda_pkg::digit_t radix_q;
  logic [CW-1:0] n_q, n_d;
  logic          neg_a_q, neg_a_d;
  logic          neg_eb_q, neg_eb_d;
  logic          add_q, add_d;
  logic          swap_q, swap_d;
  logic          iss_q, iss_d;
  logic [AW-1:0] iss_addr_q, iss_addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          carry_q, carry_d;
  logic          nz_q, nz_d;
  logic [CW-1:0] first_nz_q, first_nz_d;
  logic [CW-1:0] emit_idx_q, emit_idx_d;
  logic          out_neg_q, out_neg_d;
  logic          out_bad_q, out_bad_d;
  logic          out_last_q, out_last_d;
  srda_pkg::digit_t out_digit_q;

  srda_pkg::digit_t a_mem [MAX_DIGITS];
  srda_pkg::digit_t b_mem [MAX_DIGITS];
  srda_pkg::digit_t r_mem [MAX_DIGITS];
  srda_pkg::digit_t rd_a_q, rd_b_q;

  srda_pkg::digit_t digit_a, digit_b, r_eff, mx, u_x, u_y, u_d;
  srda_pkg::unit_ctl_t u_ctl;
  logic          u_co;
  logic          in_acc, room, bad_now, pass_end;
  logic          sum_nz;
  logic [CW-1:0] last_idx, emit_m1, cnt_inc;

  assign digit_a = s_axis_tdata[5:0];
  assign digit_b = s_axis_tdata[11:6];
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign room    = (cnt_q < MaxCnt);
  assign cnt_inc = cnt_q + CW'(1);
  assign last_idx = n_q - CW'(1);
  assign emit_m1  = emit_idx_q - CW'(1);
  assign pass_end = rd_vld_q && (rd_idx_q == '0);

  // Clamp radix into the legal range
  always_comb begin
    if (radix_q < srda_pkg::RadixMin) begin
      r_eff = srda_pkg::RadixMin;
    end else if (radix_q > srda_pkg::RadixMax) begin
      r_eff = srda_pkg::RadixMax;
    end else begin
      r_eff = radix_q;
    end
  end

  // Track the largest stored digit for the range check
  always_comb begin
    mx = max_q;
    if (room) begin
      if (digit_a > mx) mx = digit_a;
      if (digit_b > mx) mx = digit_b;
    end
    bad_now = err_q || !room || (mx >= r_eff);
  end

  // Shared digit unit: compare pass subtracts a - b for its final borrow
  always_comb begin
    u_x       = swap_q ? rd_b_q : rd_a_q;
    u_y       = swap_q ? rd_a_q : rd_b_q;
    u_ctl.sub = (state_q == S_CMP) || !add_q;
    u_ctl.cin = carry_q;
  end

  srda_digit_unit u_unit (
    .x_i     (u_x),
    .y_i     (u_y),
    .radix_i (r_eff),
    .ctl_i   (u_ctl),
    .d_o     (u_d),
    .co_o    (u_co)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    max_d      = max_q;
    n_d        = n_q;
    neg_a_d    = neg_a_q;
    neg_eb_d   = neg_eb_q;
    add_d      = add_q;
    swap_d     = swap_q;
    iss_d      = iss_q;
    iss_addr_d = iss_addr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    carry_d    = carry_q;
    nz_d       = nz_q;
    first_nz_d = first_nz_q;
    emit_idx_d = emit_idx_q;
    out_neg_d  = out_neg_q;
    out_bad_d  = out_bad_q;
    out_last_d = out_last_q;
    sum_nz     = 1'b0;

    // Issue one read per cycle, most significant address last
    if (iss_q) begin
      rd_vld_d = 1'b1;
      rd_idx_d = iss_addr_q;
      if (iss_addr_q == '0) begin
        iss_d = 1'b0;
      end else begin
        iss_addr_d = iss_addr_q - AW'(1);
      end
    end

    case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_inc;
            max_d = mx;
          end else begin
            err_d = 1'b1;
          end
          if (s_axis_tlast) begin
            cnt_d    = '0;
            err_d    = 1'b0;
            max_d    = '0;
            n_d      = cnt_inc;
            neg_a_d  = s_axis_tuser[1];
            neg_eb_d = s_axis_tuser[2] ^ s_axis_tuser[0];
            add_d    = (s_axis_tuser[1] == (s_axis_tuser[2] ^ s_axis_tuser[0]));
            swap_d   = 1'b0;
            carry_d  = 1'b0;
            nz_d     = 1'b0;
            if (bad_now) begin
              out_neg_d  = 1'b0;
              out_bad_d  = 1'b1;
              out_last_d = 1'b1;
              state_d    = S_EMOUT;
            end else begin
              out_bad_d  = 1'b0;
              iss_d      = 1'b1;
              iss_addr_d = cnt_q[AW-1:0];
              state_d    = add_d ? S_ARITH : S_CMP;
            end
          end
        end
      end
      S_CMP: begin
        if (rd_vld_q) carry_d = u_co;
        if (pass_end) begin
          swap_d     = u_co;
          carry_d    = 1'b0;
          iss_d      = 1'b1;
          iss_addr_d = last_idx[AW-1:0];
          state_d    = S_ARITH;
        end
      end
      S_ARITH: begin
        if (rd_vld_q) begin
          carry_d = u_co;
          if (u_d != '0) begin
            nz_d       = 1'b1;
            first_nz_d = CW'(rd_idx_q) + CW'(1);
          end
        end
        if (pass_end) begin
          // Pick the first digit to send and the sign
          if (add_q && u_co) begin
            emit_idx_d = '0;
            sum_nz     = 1'b1;
          end else if (nz_d) begin
            emit_idx_d = first_nz_d;
            sum_nz     = 1'b1;
          end else begin
            emit_idx_d = n_q;
          end
          out_neg_d = sum_nz && ((add_q || !swap_q) ? neg_a_q : neg_eb_q);
          state_d   = S_EMRD;
        end
      end
      S_EMRD: begin
        out_last_d = (emit_idx_q == n_q);
        state_d    = S_EMOUT;
      end
      S_EMOUT: begin
        if (m_axis_tready) begin
          if (out_last_q) begin
            state_d = S_LOAD;
          end else begin
            emit_idx_d = emit_idx_q + CW'(1);
            state_d    = S_EMRD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      cnt_q      <= '0;
      err_q      <= 1'b0;
      max_q      <= '0;
      radix_q    <= srda_pkg::RadixReset;
      n_q        <= '0;
      neg_a_q    <= 1'b0;
      neg_eb_q   <= 1'b0;
      add_q      <= 1'b0;
      swap_q     <= 1'b0;
      iss_q      <= 1'b0;
      iss_addr_q <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      carry_q    <= 1'b0;
      nz_q       <= 1'b0;
      first_nz_q <= '0;
      emit_idx_q <= '0;
      out_neg_q  <= 1'b0;
      out_bad_q  <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      err_q      <= err_d;
      max_q      <= max_d;
      if (cfg_we_i) radix_q <= cfg_wdata_i;
      n_q        <= n_d;
      neg_a_q    <= neg_a_d;
      neg_eb_q   <= neg_eb_d;
      add_q      <= add_d;
      swap_q     <= swap_d;
      iss_q      <= iss_d;
      iss_addr_q <= iss_addr_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      carry_q    <= carry_d;
      nz_q       <= nz_d;
      first_nz_q <= first_nz_d;
      emit_idx_q <= emit_idx_d;
      out_neg_q  <= out_neg_d;
      out_bad_q  <= out_bad_d;
      out_last_q <= out_last_d;
    end
  end

  // Digit memories and the registered output digit
  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      a_mem[cnt_q[AW-1:0]] <= digit_a;
      b_mem[cnt_q[AW-1:0]] <= digit_b;
    end
    if (iss_q) begin
      rd_a_q <= a_mem[iss_addr_q];
      rd_b_q <= b_mem[iss_addr_q];
    end
    if ((state_q == S_ARITH) && rd_vld_q) begin
      r_mem[rd_idx_q] <= u_d;
    end
    if (state_q == S_EMRD) begin
      out_digit_q <= (emit_idx_q == '0) ? srda_pkg::digit_t'(1) : r_mem[emit_m1[AW-1:0]];
    end else if (in_acc && s_axis_tlast && bad_now) begin
      out_digit_q <= '0;
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = (state_q == S_EMOUT);
  assign m_axis_tdata  = {2'b00, out_digit_q};
  assign m_axis_tuser  = {out_bad_q, out_neg_q};
  assign m_axis_tlast  = out_last_q;

  `SRDA_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `SRDA_ASSERT_NOW(a_err_single, m_axis_tvalid && m_axis_tuser[1],
                   m_axis_tlast && (m_axis_tdata == 8'd0) && !m_axis_tuser[0],
                   "error result malformed")
  `SRDA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= MaxCnt, "digit count overflow")
  `SRDA_ASSERT_NEXT(a_back_to_load, m_axis_tvalid && m_axis_tready && m_axis_tlast,
                    s_axis_tready, "not ready after final result")

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGIT_SLOTS   = srda_pkg::MaxDigitsDef;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 2 * DIGIT_SLOTS + 16;
  localparam int RADIX_STEPS   = 9;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  typedef struct packed {
    logic             func;
    logic             neg_a;
    logic             neg_b;
    srda_pkg::digit_t digit_a;
    srda_pkg::digit_t digit_b;
    logic             last;
  } digit_pair_t;

  typedef struct packed {
    logic             negative;
    srda_pkg::digit_t digit;
    logic             bad_input;
    logic             last_res;
  } sum_digit_t;

  typedef enum int {
    NUM_RANDOM,
    NUM_SATURATED,
    NUM_MIRROR,
    NUM_ONE_BAD,
    NUM_NOISE
  } num_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [5:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // digit_a[5:0], digit_b[11:6], zero fill
  logic [2:0]  s_axis_tuser = '0;    // func[0], neg_a[1], neg_b[2]
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // digit[5:0], zero fill
  logic [1:0]  m_axis_tuser;         // negative[0], bad_input[1]
  logic        m_axis_tlast;

  // Stimulus and expectation stores
  digit_pair_t pair_q[$];
  sum_digit_t  sum_digit_q[$];

  // Shadow of the block's state and radix register
  srda_pkg::digit_t first_store[DIGIT_SLOTS];
  srda_pkg::digit_t second_store[DIGIT_SLOTS];
  int unsigned loaded_cnt = 0;
  bit          too_long = 1'b0;
  logic [5:0]  radix_cfg = srda_pkg::RadixReset;

  // Run bookkeeping
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  logic        in_taken = 1'b0;
  digit_pair_t drv_item;
  sum_digit_t  got_digit;
  sum_digit_t  want_digit;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned pairs_seen = 0;
  int unsigned numbers_seen = 0;
  int unsigned digits_checked = 0;
  int unsigned flagged_numbers = 0;
  int unsigned radix_settings = 1;
  logic [5:0]  radix_plan[RADIX_STEPS] = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd1, 6'd37, 6'd10,
                                           6'd27, 6'd19};

  signed_radix_digit_add_sub_top #(
    .MAX_DIGITS(DIGIT_SLOTS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned radix_in_use();
    if (radix_cfg < srda_pkg::RadixMin) return 32'(srda_pkg::RadixMin);
    if (radix_cfg > srda_pkg::RadixMax) return 32'(srda_pkg::RadixMax);
    return 32'(radix_cfg);
  endfunction

  // No gap unless a pct-percent draw hits; then mostly a short gap, rarely a long one
  function automatic int unsigned idle_gap(int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Store one digit pair; on the last pair, work out the signed sum digits
  function automatic void absorb_pair(digit_pair_t p);
    int unsigned r, n, start, nres, acc, carry, hi, lo;
    int unsigned sum_digits[DIGIT_SLOTS + 1];
    int          cmp;
    bit          bad;
    logic        sign, neg_eff;
    sum_digit_t  d;
    if (loaded_cnt < DIGIT_SLOTS) begin
      first_store[loaded_cnt]  = p.digit_a;
      second_store[loaded_cnt] = p.digit_b;
      loaded_cnt++;
    end else begin
      too_long = 1'b1;
    end
    if (!p.last) return;

    r   = radix_in_use();
    n   = loaded_cnt;
    bad = too_long;
    for (int i = 0; i < n; i++)
      if (first_store[i] >= r || second_store[i] >= r) bad = 1'b1;
    loaded_cnt = 0;
    too_long   = 1'b0;

    if (bad) begin
      d = '{negative: 1'b0, digit: '0, bad_input: 1'b1, last_res: 1'b1};
      sum_digit_q.push_back(d);
      flagged_numbers++;
      return;
    end

    neg_eff = p.neg_b ^ (p.func == OP_SUB);
    carry   = 0;
    sum_digits[0] = 0;
    if (p.neg_a == neg_eff) begin
      // Same effective signs: add magnitudes, keep the carry on top
      for (int i = n; i > 0; i--) begin
        acc = first_store[i-1] + second_store[i-1] + carry;
        if (acc >= r) begin
          acc -= r;
          carry = 1;
        end else begin
          carry = 0;
        end
        sum_digits[i] = acc;
      end
      sum_digits[0] = carry;
      sign = p.neg_a;
    end else begin
      // Opposite signs: subtract the smaller magnitude from the larger
      cmp = 0;
      for (int i = 0; i < n && cmp == 0; i++) begin
        if (first_store[i] > second_store[i]) cmp = 1;
        else if (first_store[i] < second_store[i]) cmp = -1;
      end
      sign = (cmp < 0) ? neg_eff : p.neg_a;
      for (int i = n; i > 0; i--) begin
        hi = (cmp < 0) ? second_store[i-1] : first_store[i-1];
        lo = ((cmp < 0) ? first_store[i-1] : second_store[i-1]) + carry;
        if (hi >= lo) begin
          sum_digits[i] = hi - lo;
          carry = 0;
        end else begin
          sum_digits[i] = hi + r - lo;
          carry = 1;
        end
      end
    end

    // Drop leading zeros, keep one digit; zero is never negative
    start = 0;
    while (start < n && sum_digits[start] == 0) start++;
    if (start == n && sum_digits[n] == 0) sign = 1'b0;
    nres = n + 1 - start;
    for (int i = 0; i < nres; i++) begin
      d.negative  = sign;
      d.digit     = srda_pkg::digit_t'(sum_digits[start + i]);
      d.bad_input = 1'b0;
      d.last_res  = (i + 1 == nres);
      sum_digit_q.push_back(d);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Count cycles, stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Monitor: predict on each input transaction, check each output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_pair('{func: s_axis_tuser[0], neg_a: s_axis_tuser[1], neg_b: s_axis_tuser[2],
                      digit_a: s_axis_tdata[5:0], digit_b: s_axis_tdata[11:6],
                      last: s_axis_tlast});
        pairs_seen++;
        if (s_axis_tlast) numbers_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_digit = '{negative: m_axis_tuser[0], digit: m_axis_tdata[5:0],
                      bad_input: m_axis_tuser[1], last_res: m_axis_tlast};
        if (sum_digit_q.size() == 0) begin
          $error("result transaction with no expected digit pending: digit %0d",
                 got_digit.digit);
          mismatches++;
        end else begin
          want_digit = sum_digit_q.pop_front();
          check_field("negative", want_digit.negative, got_digit.negative);
          check_field("digit", want_digit.digit, got_digit.digit);
          check_field("bad_input", want_digit.bad_input, got_digit.bad_input);
          check_field("last_res", want_digit.last_res, got_digit.last_res);
          digits_checked++;
        end
      end
    end
  end

  // Driver: hold each pair until taken, then advance after a random gap
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap       <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pair_q.size() > 0) begin
        drv_item = pair_q.pop_front();
        s_axis_tdata  <= {4'b0, drv_item.digit_b, drv_item.digit_a};
        s_axis_tuser  <= {drv_item.neg_b, drv_item.neg_a, drv_item.func};
        s_axis_tlast  <= drv_item.last;
        s_axis_tvalid <= 1'b1;
        src_gap       <= idle_gap(src_idle_pct);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sink_stall > 0) begin
        m_axis_tready <= 1'b0;
        sink_stall    <= sink_stall - 1;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall    <= idle_gap(sink_idle_pct);
      end
    end
  end

  task automatic push_pair(srda_pkg::digit_t a, srda_pkg::digit_t b, logic func,
                           logic neg_a, logic neg_b, logic last);
    pair_q.push_back('{func: func, neg_a: neg_a, neg_b: neg_b, digit_a: a, digit_b: b,
                       last: last});
  endtask

  // Queue one number of len pairs; sign and operation bits vary on every pair
  task automatic queue_number(int unsigned len, num_kind_e kind);
    int unsigned      r, lead, bad_pos;
    srda_pkg::digit_t a, b;
    r       = radix_in_use();
    lead    = (kind == NUM_RANDOM && $urandom_range(2) == 0) ? $urandom_range(len - 1) : 0;
    bad_pos = $urandom_range(len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        NUM_SATURATED: begin
          a = srda_pkg::digit_t'(r - 1);
          b = $urandom_range(1) ? srda_pkg::digit_t'(r - 1)
                                : srda_pkg::digit_t'($urandom_range(r - 1));
        end
        NUM_NOISE: begin
          a = srda_pkg::digit_t'($urandom_range(63));
          b = srda_pkg::digit_t'($urandom_range(63));
        end
        default: begin
          a = srda_pkg::digit_t'($urandom_range(r - 1));
          b = srda_pkg::digit_t'($urandom_range(r - 1));
        end
      endcase
      if (i < lead) begin
        a = '0;
        b = '0;
      end
      if (kind == NUM_MIRROR) b = a;
      if (kind == NUM_ONE_BAD && i == bad_pos) begin
        if ($urandom_range(1)) a = srda_pkg::digit_t'($urandom_range(63, r));
        else b = srda_pkg::digit_t'($urandom_range(63, r));
      end
      push_pair(a, b, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                i + 1 == len);
    end
  endtask

  // Mostly short numbers, some long, a few past the digit store
  task automatic run_random(int unsigned target, bit force_long);
    int unsigned sent, len, pick;
    num_kind_e   kind;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (force_long && sent == 0) len = $urandom_range(DIGIT_SLOTS + 2, DIGIT_SLOTS + 1);
      else if (pick < 70) len = $urandom_range(6, 1);
      else if (pick < 95) len = $urandom_range(DIGIT_SLOTS, 7);
      else len = $urandom_range(DIGIT_SLOTS + 3, DIGIT_SLOTS + 1);
      pick = $urandom_range(99);
      if (pick < 45) kind = NUM_RANDOM;
      else if (pick < 60) kind = NUM_SATURATED;
      else if (pick < 72) kind = NUM_MIRROR;
      else if (pick < 85) kind = NUM_ONE_BAD;
      else kind = NUM_NOISE;
      queue_number(len, kind);
      sent += len;
    end
  endtask

  // Wait until every pair is taken and every result digit is back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pair_q.size() != 0 || s_axis_tvalid || sum_digit_q.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_radix(logic [5:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    radix_cfg    = value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    radix_settings++;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed numbers at the reset radix
    push_pair(6'd0, 6'd0, OP_ADD, 1'b1, 1'b1, 1'b1);    // negative zeros sum to plain zero
    push_pair(6'd18, 6'd18, OP_ADD, 1'b0, 1'b0, 1'b1);  // carry out of the top digit
    push_pair(6'd5, 6'd5, OP_SUB, 1'b0, 1'b0, 1'b1);    // equal magnitudes cancel
    push_pair(6'd3, 6'd7, OP_SUB, 1'b0, 1'b0, 1'b1);    // smaller minus larger
    push_pair(6'd3, 6'd7, OP_ADD, 1'b1, 1'b0, 1'b1);
    push_pair(6'd7, 6'd3, OP_ADD, 1'b0, 1'b1, 1'b1);
    push_pair(6'd6, 6'd5, OP_SUB, 1'b1, 1'b1, 1'b1);
    push_pair(6'd5, 6'd6, OP_SUB, 1'b0, 1'b1, 1'b1);    // subtract a negative
    push_pair(6'd19, 6'd0, OP_ADD, 1'b0, 1'b0, 1'b1);   // digit equal to the radix
    push_pair(6'd0, 6'd63, OP_SUB, 1'b1, 1'b0, 1'b1);   // all-ones digit
    push_pair(6'd18, 6'd0, OP_ADD, 1'b0, 1'b0, 1'b0);   // carry ripples through
    push_pair(6'd18, 6'd1, OP_ADD, 1'b0, 1'b0, 1'b1);
    push_pair(6'd0, 6'd0, OP_ADD, 1'b0, 1'b0, 1'b0);    // leading zeros, zero result
    push_pair(6'd0, 6'd0, OP_ADD, 1'b0, 1'b0, 1'b0);
    push_pair(6'd3, 6'd3, OP_SUB, 1'b1, 1'b1, 1'b1);
    push_pair(6'd4, 6'd4, OP_ADD, 1'b0, 1'b0, 1'b0);    // top digits tie, lower decides
    push_pair(6'd2, 6'd9, OP_SUB, 1'b0, 1'b0, 1'b1);
    push_pair(6'd1, 6'd2, OP_ADD, 1'b0, 1'b0, 1'b0);    // bad digit in the middle
    push_pair(6'd20, 6'd3, OP_ADD, 1'b0, 1'b0, 1'b0);
    push_pair(6'd4, 6'd5, OP_ADD, 1'b0, 1'b0, 1'b1);
    push_pair(6'd1, 6'd0, OP_SUB, 1'b0, 1'b0, 1'b0);    // borrow ripples through
    push_pair(6'd0, 6'd0, OP_SUB, 1'b0, 1'b0, 1'b0);
    push_pair(6'd0, 6'd1, OP_SUB, 1'b0, 1'b0, 1'b1);
    run_random(30, 1'b0);

    // Sweep the radix, extremes and out-of-range codes included
    radix_plan[7] = 6'($urandom_range(63));
    for (int k = 0; k < RADIX_STEPS; k++) begin
      wait_idle();
      case (k % 3)
        0: begin
          src_idle_pct  = 30;
          sink_idle_pct = 25;
        end
        1: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
        default: begin
          src_idle_pct  = 60;
          sink_idle_pct = 45;
        end
      endcase
      write_radix(radix_plan[k]);
      run_random(21, k == 2 || k == 5);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Ran %0d numbers from %0d digit pairs over %0d radix settings; %0d flagged bad.",
             numbers_seen, pairs_seen, radix_settings, flagged_numbers);
    $display("Compared %0d result digits field by field, %0d mismatches.",
             digits_checked, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
